>>> src/csv_field_splitter_assert.svh
// ----------------------------------------------------------------------------
// csv_field_splitter assertion macros
// Concurrent assertion wrappers for the splitter RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define CSVFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CSVFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSVFS_ASSERT(lbl, prop, msg)
`define CSVFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the streaming CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  // Field counter limit and derived widths
  localparam int MAX_FIELDS = 256;
  localparam int IDX_W      = $clog2(MAX_FIELDS);
  localparam int COUNT_W    = $clog2(MAX_FIELDS + 1);

  // Special characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] SEP_RESET = 8'h2C;

  // Parser mode
  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_QPEND  = 2'd3
  } mode_t;

  // One accepted input item
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } item_t;

  // One parser result
  typedef struct packed {
    logic               emit;
    logic [7:0]         data;
    logic               data_valid;
    logic [IDX_W-1:0]   field_index;
    logic               field_end;
    logic               line_end;
    logic [COUNT_W-1:0] field_count;
  } result_t;

endpackage

>>> src/csvfs_in_reg.sv
// ----------------------------------------------------------------------------
// csvfs_in_reg
// Input register: captures one byte transfer and holds it until the parser
// advances.
// ----------------------------------------------------------------------------
module csvfs_in_reg
  import csvfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       item_valid,
  output item_t      item,
  input  logic       advance
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Stall only while a held item cannot move on
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  // Fill on a transfer, empty when the parser consumes the item
  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on a transfer
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data <= in_byte;
      item_r.eoi  <= in_end_of_input;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> src/csvfs_parser.sv
// ----------------------------------------------------------------------------
// csvfs_parser
// Line and field state machine: one item per advance, at most one result.
// ----------------------------------------------------------------------------
`include "csv_field_splitter_assert.svh"

module csvfs_parser
  import csvfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  item_t      item,
  input  logic       advance,
  output result_t    res
);

  localparam logic [IDX_W-1:0] FIELD_LAST = IDX_W'(MAX_FIELDS - 1);

  logic [7:0]       sep_r;
  mode_t            mode_r, mode_nxt;
  logic             after_cr_r, after_cr_nxt;
  logic             has_r, has_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;

  logic [7:0]       c;
  logic             is_eol;
  logic             line_clear;
  logic             plain;
  logic             emit_byte;
  logic [7:0]       byte_val;
  logic             sep_hit;

  assign c       = item.data;
  assign is_eol  = (c == CH_CR) || (c == CH_LF);
  assign sep_hit = (c == sep_r);

  // Separator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_wr_en) begin
      sep_r <= cfg_wr_data;
    end
  end

  // Next state and result
  always_comb begin
    mode_nxt     = mode_r;
    after_cr_nxt = after_cr_r;
    has_nxt      = has_r;
    cur_nxt      = cur_r;
    line_clear   = 1'b0;
    plain        = 1'b0;
    emit_byte    = 1'b0;
    byte_val     = c;
    res          = '0;
    res.field_index = cur_r;

    if (item.eoi) begin
      // End of input closes a nonempty line, otherwise nothing
      after_cr_nxt = 1'b0;
      line_clear   = 1'b1;
      if (has_r) begin
        res.emit        = 1'b1;
        res.field_end   = 1'b1;
        res.line_end    = 1'b1;
        res.field_count = COUNT_W'(cur_r) + COUNT_W'(1);
      end
    end else if (after_cr_r && (c == CH_LF)) begin
      // Drop the LF of a CRLF pair
      after_cr_nxt = 1'b0;
    end else if (is_eol) begin
      after_cr_nxt = (c == CH_CR);
      line_clear   = 1'b1;
      res.emit     = 1'b1;
      res.line_end = 1'b1;
      if (has_r) begin
        res.field_end   = 1'b1;
        res.field_count = COUNT_W'(cur_r) + COUNT_W'(1);
      end
    end else begin
      after_cr_nxt = 1'b0;
      has_nxt      = 1'b1;
      case (mode_r)
        MODE_START: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_QUOTED;
          end else begin
            plain = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_QPEND;
          end else begin
            emit_byte = 1'b1;
          end
        end
        MODE_QPEND: begin
          if (c == CH_QUOTE) begin
            mode_nxt  = MODE_QUOTED;
            emit_byte = 1'b1;
            byte_val  = CH_QUOTE;
          end else begin
            plain = 1'b1;
          end
        end
        default: begin
          plain = 1'b1;
        end
      endcase
    end

    // Unquoted byte: separator ends the field, anything else is content
    if (plain) begin
      if (sep_hit) begin
        res.emit      = 1'b1;
        res.field_end = 1'b1;
        mode_nxt      = MODE_START;
        if (cur_r < FIELD_LAST) begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end else begin
        mode_nxt  = MODE_PLAIN;
        emit_byte = 1'b1;
      end
    end

    if (emit_byte) begin
      res.emit       = 1'b1;
      res.data       = byte_val;
      res.data_valid = 1'b1;
    end

    // Start a fresh line
    if (line_clear) begin
      mode_nxt = MODE_START;
      has_nxt  = 1'b0;
      cur_nxt  = '0;
    end
  end

  // State registers advance once per consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_START;
      after_cr_r <= 1'b0;
      has_r      <= 1'b0;
      cur_r      <= '0;
    end else if (advance) begin
      mode_r     <= mode_nxt;
      after_cr_r <= after_cr_nxt;
      has_r      <= has_nxt;
      cur_r      <= cur_nxt;
    end
  end

  `CSVFS_ASSERT(a_line_end_clears, advance && res.emit && res.line_end |=> cur_r == '0 && mode_r == MODE_START && !has_r, "line state not cleared after line end")
  `CSVFS_ASSERT(a_byte_not_mark, res.data_valid |-> !res.field_end && !res.line_end, "content byte carries an end mark")
  `CSVFS_ASSERT(a_count_matches, res.line_end && res.field_end |-> res.field_count != '0 && has_r, "closed line reports no fields")
  `CSVFS_ASSERT_ALWAYS(a_empty_mode, !has_r |-> mode_r == MODE_START && cur_r == '0, "parser left line start without content")

endmodule

>>> src/csvfs_out_reg.sv
// ----------------------------------------------------------------------------
// csvfs_out_reg
// Result register: loads a parser result and holds it until the transfer.
// ----------------------------------------------------------------------------
module csvfs_out_reg
  import csvfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  result_t            res,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic [IDX_W-1:0]   out_field_index,
  output logic               out_field_end,
  output logic               out_line_end,
  output logic [COUNT_W-1:0] out_field_count
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  logic    ready;
  logic    load;

  // Free when empty or when the held result leaves this cycle
  assign ready   = !valid_r || !out_stall;
  assign advance = item_valid && ready;
  assign load    = advance && res.emit;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = res_r.data;
  assign out_byte_valid  = res_r.data_valid;
  assign out_field_index = res_r.field_index;
  assign out_field_end   = res_r.field_end;
  assign out_line_end    = res_r.line_end;
  assign out_field_count = res_r.field_count;

endmodule

>>> src/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Streaming CSV splitter: bytes in, field bytes and field/line marks out.
// ----------------------------------------------------------------------------
// Each byte is captured in the input register and its result is loaded into
// the result register to transfer; bytes that give no result use only the input stage.
// Throughput: one byte per cycle; the input register, parser and result
// register form a two-stage pipeline that a stalled output holds in place.
// Reset (rst_n low, synchronous): pipeline empty, line state at field start,
// separator back to comma.
module csv_field_splitter
  import csvfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_end_of_input,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic [IDX_W-1:0]   out_field_index,
  output logic               out_field_end,
  output logic               out_line_end,
  output logic [COUNT_W-1:0] out_field_count
);

  logic    item_valid;
  item_t   item;
  logic    advance;
  result_t res;

  // Capture input bytes
  csvfs_in_reg u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .item_valid      (item_valid),
    .item            (item),
    .advance         (advance)
  );

  // Parse one byte per advance
  csvfs_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .advance     (advance),
    .res         (res)
  );

  // Hold results for the output transfer
  csvfs_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .res             (res),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_field_index (out_field_index),
    .out_field_end   (out_field_end),
    .out_line_end    (out_line_end),
    .out_field_count (out_field_count)
  );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// csv_field_splitter testbench
// Feeds CSV text (directed corner cases, then random records and noise) into
// the splitter under random gaps and stalls. Each accepted byte is run through
// a local copy of the parser, and every output transfer is compared field by
// field with the oldest predicted token. The separator is changed between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import csvfs_pkg::*;

  // One predicted output token
  typedef struct packed {
    logic [7:0]         data;
    logic               data_valid;
    logic [IDX_W-1:0]   field_idx;
    logic               field_end;
    logic               line_end;
    logic [COUNT_W-1:0] field_count;
  } token_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [7:0]         cfg_wr_data = SEP_RESET;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte = 8'h00;
  logic               in_end_of_input = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               out_byte_valid;
  logic [IDX_W-1:0]   out_field_index;
  logic               out_field_end;
  logic               out_line_end;
  logic [COUNT_W-1:0] out_field_count;

  // Stimulus and prediction state
  item_t  char_q[$];
  token_t token_q[$];
  int     queued = 0;
  int     err_cnt = 0;
  int     send_gap_pct = 0;
  int     recv_gap_pct = 0;
  bit     hold_armed = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_left = 0;

  // Parser copy
  logic [7:0] sep_char = SEP_RESET;
  mode_t      pmode = MODE_START;
  bit         cr_seen = 1'b0;
  bit         line_open = 1'b0;
  int         field_no = 0;

  csv_field_splitter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_field_index (out_field_index),
    .out_field_end   (out_field_end),
    .out_line_end    (out_line_end),
    .out_field_count (out_field_count)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------
  function automatic token_t make_tok(logic [7:0] b, logic v, logic fe, logic le, int cnt);
    token_t t;
    t.data        = b;
    t.data_valid  = v;
    t.field_idx   = field_no[IDX_W-1:0];
    t.field_end   = fe;
    t.line_end    = le;
    t.field_count = cnt[COUNT_W-1:0];
    return t;
  endfunction

  // Close a line with content: count saturates at MAX_FIELDS
  function automatic token_t close_line_tok();
    token_t t;
    t = make_tok(8'h00, 1'b0, 1'b1, 1'b1,
                 (field_no + 1 > MAX_FIELDS) ? MAX_FIELDS : field_no + 1);
    pmode     = MODE_START;
    line_open = 1'b0;
    field_no  = 0;
    return t;
  endfunction

  // Unquoted byte: separator ends the field, anything else is content
  function automatic token_t plain_char(logic [7:0] c);
    token_t t;
    if (c == sep_char) begin
      t = make_tok(8'h00, 1'b0, 1'b1, 1'b0, 0);
      if (field_no < MAX_FIELDS - 1) field_no++;
      pmode = MODE_START;
    end else begin
      pmode = MODE_PLAIN;
      t = make_tok(c, 1'b1, 1'b0, 1'b0, 0);
    end
    return t;
  endfunction

  // Advance the parser by one item; return 1 when it yields a token
  function automatic bit split_char(input logic [7:0] c, input logic eoi, output token_t t);
    t = '0;
    if (eoi) begin
      cr_seen = 1'b0;
      if (!line_open) begin
        pmode    = MODE_START;
        field_no = 0;
        return 1'b0;
      end
      t = close_line_tok();
      return 1'b1;
    end
    // Swallow the LF of a CRLF pair
    if (cr_seen) begin
      cr_seen = 1'b0;
      if (c == CH_LF) return 1'b0;
    end
    if (c == CH_CR || c == CH_LF) begin
      cr_seen = (c == CH_CR);
      if (!line_open) begin
        t = make_tok(8'h00, 1'b0, 1'b0, 1'b1, 0);
        pmode    = MODE_START;
        field_no = 0;
        return 1'b1;
      end
      t = close_line_tok();
      return 1'b1;
    end
    line_open = 1'b1;
    case (pmode)
      MODE_START: begin
        if (c == CH_QUOTE) begin
          pmode = MODE_QUOTED;
          return 1'b0;
        end
        t = plain_char(c);
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          pmode = MODE_QPEND;
          return 1'b0;
        end
        t = make_tok(c, 1'b1, 1'b0, 1'b0, 0);
      end
      MODE_QPEND: begin
        if (c == CH_QUOTE) begin
          pmode = MODE_QUOTED;
          t = make_tok(CH_QUOTE, 1'b1, 1'b0, 1'b0, 0);
        end else begin
          t = plain_char(c);
        end
      end
      default: t = plain_char(c);
    endcase
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict each accepted transfer, then offer the next byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    item_t  nxt;
    token_t tok;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_byte         <= 8'h00;
      in_end_of_input <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (split_char(in_byte, in_end_of_input, tok)) token_q = {token_q, tok};
      end
      // Hold a stalled transfer; otherwise load the next byte or go idle
      if (!in_valid || !in_stall) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = char_q.pop_front();
          in_valid        <= 1'b1;
          in_byte         <= nxt.data;
          in_end_of_input <= nxt.eoi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each output transfer with the oldest predicted token
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    token_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("output transfer with no predicted token");
        err_cnt++;
      end else begin
        t = token_q.pop_front();
        check_field("out_byte", int'(t.data), int'(out_byte));
        check_field("out_byte_valid", int'(t.data_valid), int'(out_byte_valid));
        check_field("out_field_index", int'(t.field_idx), int'(out_field_index));
        check_field("out_field_end", int'(t.field_end), int'(out_field_end));
        check_field("out_line_end", int'(t.line_end), int'(out_line_end));
        check_field("out_field_count", int'(t.field_count), int'(out_field_count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_char(logic [7:0] c, logic eoi = 1'b0);
    item_t it;
    it.data = c;
    it.eoi  = eoi;
    char_q = {char_q, it};
    queued++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Random byte that is ordinary content under the current separator
  function automatic logic [7:0] content_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_LF || c == CH_QUOTE || c == sep_char);
    return c;
  endfunction

  // One field: empty, plain, or quoted with separators and doubled quotes
  task automatic push_field();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 5);
    if (kind < 2) return;
    if (kind < 6) begin
      repeat (len) push_char(content_byte());
    end else begin
      push_char(CH_QUOTE);
      repeat (len) begin
        case ($urandom_range(0, 5))
          0: push_char(sep_char);
          1: begin
            push_char(CH_QUOTE);
            push_char(CH_QUOTE);
          end
          default: push_char(content_byte());
        endcase
      end
      // Mostly close the quote; sometimes add literal bytes after it
      if ($urandom_range(0, 9) != 0) begin
        push_char(CH_QUOTE);
        if ($urandom_range(0, 3) == 0) begin
          push_char(content_byte());
          push_char(CH_QUOTE);
        end
      end
    end
  endtask

  // One line of fields with a random terminator, or a burst of noise
  task automatic push_record();
    int nf;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 8))
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      return;
    end
    nf = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    for (int i = 0; i < nf; i++) begin
      if (i != 0) push_char(sep_char);
      push_field();
    end
    case ($urandom_range(0, 3))
      0: push_char(CH_CR);
      1: push_char(CH_LF);
      2: begin
        push_char(CH_CR);
        push_char(CH_LF);
      end
      default: push_char(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  task automatic fill_records(int n);
    int goal;
    goal = queued + n;
    while (queued < goal) push_record();
  endtask

  // Wait until every byte is in and every token is out, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (char_q.size() != 0 || in_valid || token_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_separator(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sep_char     = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Sparse sender, busy receiver; default comma separator
    send_gap_pct = 13;
    recv_gap_pct = 48;
    // Quoted field with separator, doubled quote, literal tail; trailing separator
    push_text("\"x,\"\"y\"z,");
    push_char(CH_LF);
    // Empty lines by CR, by CRLF, by LF; end of input on an empty line
    push_char(CH_CR);
    push_char(CH_CR);
    push_char(CH_LF);
    push_char(CH_LF);
    push_char(8'h00, 1'b1);
    // Unclosed quote runs to the line end
    push_text("\"ab");
    push_char(CH_CR);
    // Extreme bytes, line closed by end of input
    push_char(8'h00);
    push_char(8'hFF);
    push_char(8'h5A, 1'b1);
    fill_records(30);
    // Saturate the field counter
    repeat (MAX_FIELDS + 2) push_char(sep_char);
    push_char(CH_LF);
    fill_records(30);
    drain();

    // Busy sender, sparse receiver
    set_separator(8'hFF);
    send_gap_pct = 48;
    recv_gap_pct = 13;
    fill_records(50);
    drain();

    // No gaps; one long receiver hold-off to back up the pipeline
    set_separator(8'h00);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_armed   = 1'b1;
    fill_records(50);
    drain();

    // Separators that collide with line ends and quotes
    set_separator(CH_CR);
    fill_records(20);
    drain();
    set_separator(CH_QUOTE);
    fill_records(20);
    drain();
    set_separator(SEP_RESET);
    fill_records(20);
    drain();

    repeat (8) @(posedge clk);
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/csvfs_pkg.sv
src/csvfs_in_reg.sv
src/csvfs_parser.sv
src/csvfs_out_reg.sv
src/csv_field_splitter.sv
dv/testbench.sv
